@@ hw/rtl/cdc_pkg.sv @@
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types and constants for the collatz descent checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cdc_pkg;

    localparam int MULT_W      = 64;
    localparam int START_EXP_W = 7;
    localparam int HORIZON_W   = 16;
    localparam int STEP_W      = 17;
    localparam int OUTCOME_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_EXP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON   = 1'd1;

    localparam logic [START_EXP_W-1:0] START_EXP_RESET = 7'd10;
    localparam logic [HORIZON_W-1:0]   HORIZON_RESET   = 16'd1000;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_DESCENDED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_SURVIVED  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic ovf;  // result needs more than the value width
        logic ge;   // subtract form: minuend not below subtrahend
    } t_alu_flags;

endpackage

`default_nettype wire

@@ hw/rtl/collatz_descent_checker.sv @@
// From input to result beat: setup steps that triple the value and double the seed k times,
//   two decrements, one start compare, one map step per cycle up to the horizon H, one load.
// Takes no new item until the last one's result is loaded into the output register.
// Reset (synchronous, active low) returns the sequencer to idle, drops the output
//   beat and loads start_exponent = 10 and horizon = 1000.
// ----------------------------------------------------------------------------
// collatz_descent_checker
// Iterates the shortcut Collatz map on seeds m*2^k-1 until descent, horizon
// or overflow, one map step per cycle on a shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module collatz_descent_checker #(
    parameter int VALUE_BITS = 128
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cdc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [cdc_pkg::MULT_W-1:0]      i_multiplier,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [cdc_pkg::OUTCOME_W-1:0]        o_outcome,
    output logic [cdc_pkg::STEP_W-1:0]           o_exit_step
);

    localparam int AW = VALUE_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_DEC_SEED, S_DEC_X, S_CMP, S_RUN, S_DONE
    } t_state;

    t_state                              r_state;
    logic [VALUE_BITS-1:0]               r_seed;
    logic [VALUE_BITS-1:0]               r_x;
    logic [cdc_pkg::START_EXP_W-1:0]     r_cnt;
    logic [cdc_pkg::STEP_W-1:0]          r_t;
    logic [cdc_pkg::START_EXP_W-1:0]     r_start_exp;
    logic [cdc_pkg::HORIZON_W-1:0]       r_horizon;
    logic [cdc_pkg::OUTCOME_W-1:0]       r_res_outcome;
    logic [cdc_pkg::STEP_W-1:0]          r_res_step;
    logic                                r_out_valid;
    logic [cdc_pkg::OUTCOME_W-1:0]       r_outcome;
    logic [cdc_pkg::STEP_W-1:0]          r_exit_step;

    logic [AW-1:0]                       alu_a;
    logic [AW-1:0]                       alu_b;
    logic                                alu_cin;
    logic [AW-1:0]                       alu_sum;
    cdc_pkg::t_alu_flags                 alu_flags;

    logic                                in_acc;
    logic [cdc_pkg::STEP_W-1:0]          n_t;
    logic [cdc_pkg::STEP_W-1:0]          horizon_ext;
    logic [cdc_pkg::STEP_W-1:0]          survive_step;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign n_t          = r_t + cdc_pkg::STEP_W'(1);
    assign horizon_ext  = cdc_pkg::STEP_W'(r_horizon);
    assign survive_step = horizon_ext + cdc_pkg::STEP_W'(1);
    assign o_out_valid  = r_out_valid;
    assign o_outcome    = r_outcome;
    assign o_exit_step  = r_exit_step;

    // operand select for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (r_state)
            S_SETUP: begin
                alu_a = {1'b0, r_x, 1'b0};
                alu_b = {2'b00, r_x};
            end
            S_DEC_SEED: begin
                alu_a = {2'b00, r_seed};
                alu_b = {2'b00, {VALUE_BITS{1'b1}}};
            end
            S_DEC_X: begin
                alu_a = {2'b00, r_x};
                alu_b = {2'b00, {VALUE_BITS{1'b1}}};
            end
            S_CMP: begin
                alu_a   = {2'b00, r_x};
                alu_b   = {2'b00, ~r_seed};
                alu_cin = 1'b1;
            end
            S_RUN: begin
                if (r_x[0]) begin
                    alu_a   = {1'b0, r_x, 1'b0};
                    alu_b   = {2'b00, r_x};
                    alu_cin = 1'b1;
                end else begin
                    // odd steps cannot descend, so only x/2 against seed matters
                    alu_a   = {3'b000, r_x[VALUE_BITS-1:1]};
                    alu_b   = {2'b00, ~r_seed};
                    alu_cin = 1'b1;
                end
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_cin = 1'b0;
            end
        endcase
    end

    cdc_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_cin   (alu_cin),
        .o_sum   (alu_sum),
        .o_flags (alu_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_exp <= cdc_pkg::START_EXP_RESET;
            r_horizon   <= cdc_pkg::HORIZON_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cdc_pkg::REG_START_EXP: r_start_exp <= i_cfg_data[cdc_pkg::START_EXP_W-1:0];
                cdc_pkg::REG_HORIZON:   r_horizon   <= i_cfg_data[cdc_pkg::HORIZON_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_seed <= VALUE_BITS'(i_multiplier);
                        r_x    <= VALUE_BITS'(i_multiplier);
                        r_cnt  <= r_start_exp;
                        r_t    <= cdc_pkg::STEP_W'(r_start_exp) + cdc_pkg::STEP_W'(1);
                        if (i_multiplier == '0) begin
                            r_res_outcome <= cdc_pkg::OUT_OVERFLOW;
                            r_res_step    <= cdc_pkg::STEP_W'(r_start_exp)
                                             + cdc_pkg::STEP_W'(1);
                            r_state       <= S_DONE;
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DEC_SEED;
                    end else if (r_seed[VALUE_BITS-1] || alu_flags.ovf) begin
                        r_res_outcome <= cdc_pkg::OUT_OVERFLOW;
                        r_res_step    <= r_t;
                        r_state       <= S_DONE;
                    end else begin
                        r_x    <= alu_sum[VALUE_BITS-1:0];
                        r_seed <= {r_seed[VALUE_BITS-2:0], 1'b0};
                        r_cnt  <= r_cnt - cdc_pkg::START_EXP_W'(1);
                    end
                end
                S_DEC_SEED: begin
                    r_seed  <= alu_sum[VALUE_BITS-1:0];
                    r_state <= S_DEC_X;
                end
                S_DEC_X: begin
                    r_x     <= {1'b0, alu_sum[VALUE_BITS-1:1]};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!alu_flags.ge) begin
                        r_res_outcome <= cdc_pkg::OUT_DESCENDED;
                        r_res_step    <= r_t;
                        r_state       <= S_DONE;
                    end else if (r_t >= horizon_ext) begin
                        r_res_outcome <= cdc_pkg::OUT_SURVIVED;
                        r_res_step    <= survive_step;
                        r_state       <= S_DONE;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_x[0]) begin
                        if (alu_flags.ovf) begin
                            r_res_outcome <= cdc_pkg::OUT_OVERFLOW;
                            r_res_step    <= r_t;
                            r_state       <= S_DONE;
                        end else begin
                            r_x <= alu_sum[VALUE_BITS:1];
                            r_t <= n_t;
                            if (n_t >= horizon_ext) begin
                                r_res_outcome <= cdc_pkg::OUT_SURVIVED;
                                r_res_step    <= survive_step;
                                r_state       <= S_DONE;
                            end
                        end
                    end else begin
                        r_x <= {1'b0, r_x[VALUE_BITS-1:1]};
                        r_t <= n_t;
                        if (!alu_flags.ge) begin
                            r_res_outcome <= cdc_pkg::OUT_DESCENDED;
                            r_res_step    <= n_t;
                            r_state       <= S_DONE;
                        end else if (n_t >= horizon_ext) begin
                            r_res_outcome <= cdc_pkg::OUT_SURVIVED;
                            r_res_step    <= survive_step;
                            r_state       <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // hand off once the output register is free or draining
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_outcome   <= r_res_outcome;
                        r_exit_step <= r_res_step;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_zero_mult_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_multiplier == '0) |=>
            (r_state == S_DONE) && (r_res_outcome == cdc_pkg::OUT_OVERFLOW))
        else $error("zero multiplier did not report overflow");

    a_run_below_horizon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_t < horizon_ext))
        else $error("map step taken at or beyond the horizon");

    a_run_not_descended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_x >= r_seed))
        else $error("iteration continued after value fell below seed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted again without finishing the item");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_outcome == cdc_pkg::OUT_DESCENDED)
            || (o_outcome == cdc_pkg::OUT_SURVIVED)
            || (o_outcome == cdc_pkg::OUT_OVERFLOW))
        else $error("result beat carries an unknown outcome code");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cdc_alu.sv @@
// ----------------------------------------------------------------------------
// cdc_alu
// Shared wide adder with carry-in, used for tripling, decrement and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module cdc_alu #(
    parameter int WIDTH = 130
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    input  wire logic             i_cin,
    output logic [WIDTH-1:0]      o_sum,
    output cdc_pkg::t_alu_flags   o_flags
);

    always_comb begin
        o_sum         = i_a + i_b + WIDTH'(i_cin);
        // two guard bits sit above the value width
        o_flags.ovf   = |o_sum[WIDTH-1:WIDTH-2];
        o_flags.ge    = o_sum[WIDTH-2];
    end

endmodule

`default_nettype wire

@@ dv/tb_collatz_descent_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_collatz_descent_checker
// Drives multipliers through the descent checker under several exponent and
// horizon settings, predicts outcome and exit step for each accepted beat and
// checks every result beat in order, with random gaps, stalls and long
// output hold-offs that back up the input.
// ----------------------------------------------------------------------------

module tb_collatz_descent_checker;

    typedef struct packed {
        logic [cdc_pkg::MULT_W-1:0]    mult;
        logic [cdc_pkg::OUTCOME_W-1:0] outcome;
        logic [cdc_pkg::STEP_W-1:0]    step;
    } t_exit_rec;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_cfg_we     = 1'b0;
    logic [cdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [cdc_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_ready;
    logic [cdc_pkg::MULT_W-1:0]     i_multiplier = '0;
    logic                           o_out_valid;
    logic                           i_out_ready  = 1'b0;
    logic [cdc_pkg::OUTCOME_W-1:0]  o_outcome;
    logic [cdc_pkg::STEP_W-1:0]     o_exit_step;

    // shadow of the block's registers
    logic [cdc_pkg::START_EXP_W-1:0] start_exp = cdc_pkg::START_EXP_RESET;
    logic [cdc_pkg::HORIZON_W-1:0]   horizon   = cdc_pkg::HORIZON_RESET;

    logic [cdc_pkg::MULT_W-1:0] pending_mults[$];
    t_exit_rec                  expected_exits[$];
    int                         fail_count = 0;

    collatz_descent_checker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_multiplier (i_multiplier),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_outcome    (o_outcome),
        .o_exit_step  (o_exit_step)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // walk the shortcut map from step k+1 until descent, horizon or overflow
    function automatic t_exit_rec predict_exit(logic [cdc_pkg::MULT_W-1:0] m,
                                               logic [cdc_pkg::START_EXP_W-1:0] k,
                                               logic [cdc_pkg::HORIZON_W-1:0] h);
        logic [127:0] seed;
        logic [127:0] x;
        logic [129:0] wide;
        logic         fits;
        logic         done;
        int unsigned  t;
        int           i;
        t_exit_rec    r;
        r.mult = m;
        seed   = {64'd0, m};
        x      = {64'd0, m};
        fits   = (m != 0);
        t      = k + 1;
        for (i = 0; i < k; i++) begin
            if (fits) begin
                if (seed[127]) begin
                    fits = 1'b0;
                end else begin
                    seed = seed << 1;
                    wide = {2'b00, x} + {1'b0, x, 1'b0};
                    if (wide[129:128] != 2'b00)
                        fits = 1'b0;
                    else
                        x = wide[127:0];
                end
            end
        end
        if (!fits) begin
            r.outcome = cdc_pkg::OUT_OVERFLOW;
            r.step    = t[cdc_pkg::STEP_W-1:0];
            return r;
        end
        seed      = seed - 1;
        x         = (x - 1) >> 1;
        r.outcome = cdc_pkg::OUT_SURVIVED;
        r.step    = {1'b0, h} + 17'd1;
        if (x < seed) begin
            r.outcome = cdc_pkg::OUT_DESCENDED;
            r.step    = t[cdc_pkg::STEP_W-1:0];
            return r;
        end
        done = 1'b0;
        while (!done && t < h) begin
            if (x[0]) begin
                wide = {2'b00, x} + {1'b0, x, 1'b0} + 130'd1;
                if (wide[129:128] != 2'b00) begin
                    r.outcome = cdc_pkg::OUT_OVERFLOW;
                    r.step    = t[cdc_pkg::STEP_W-1:0];
                    done      = 1'b1;
                end else begin
                    x = wide[128:1];
                end
            end else begin
                x = x >> 1;
            end
            if (!done) begin
                t++;
                if (x < seed) begin
                    r.outcome = cdc_pkg::OUT_DESCENDED;
                    r.step    = t[cdc_pkg::STEP_W-1:0];
                    done      = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // mostly odd multipliers sized so that 3^k*m still fits, some noise
    function automatic logic [cdc_pkg::MULT_W-1:0] pick_multiplier(int k);
        logic [cdc_pkg::MULT_W-1:0] r;
        int                         fit_bits;
        int                         width;
        int                         sel;
        r        = {$urandom, $urandom};
        sel      = $urandom_range(0, 19);
        fit_bits = 128 - (k * 1585 + 999) / 1000;
        if (fit_bits > 64)
            fit_bits = 64;
        if (fit_bits < 1)
            fit_bits = 1;
        width = $urandom_range(1, fit_bits);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return r;
        r = r >> (64 - width);
        if (sel == 2)
            return r & ~64'd1;
        r[0] = 1'b1;
        return r;
    endfunction

    // sender: bursts of beats separated by random gaps
    int        burst_left;
    int        gap_left;
    t_exit_rec acc_rec;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                acc_rec        = predict_exit(i_multiplier, start_exp, horizon);
                expected_exits = {expected_exits, acc_rec};
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_mults.size() > 0) begin
                    i_in_valid   <= 1'b1;
                    i_multiplier <= pending_mults.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall modes that change every so often, plus long hold-offs
    int        beats_seen = 0;
    int        hold_left  = 0;
    int        mode_left  = 0;
    int        stall_mode = 0;
    int        cyc_count  = 0;
    t_exit_rec exp_rec;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_exits.size() == 0) begin
                    $display("%0t: result beat with nothing expected, outcome %0d step %0d",
                             $time, o_outcome, o_exit_step);
                    fail_count++;
                end else begin
                    exp_rec = expected_exits.pop_front();
                    if (o_outcome !== exp_rec.outcome) begin
                        $display("%0t: m=%h outcome expected %0d actual %0d",
                                 $time, exp_rec.mult, exp_rec.outcome, o_outcome);
                        fail_count++;
                    end
                    if (o_exit_step !== exp_rec.step) begin
                        $display("%0t: m=%h exit_step expected %0d actual %0d",
                                 $time, exp_rec.mult, exp_rec.step, o_exit_step);
                        fail_count++;
                    end
                end
                beats_seen++;
                if (beats_seen == 40 || beats_seen == 400)
                    hold_left = 400;
            end
            cyc_count++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    default: i_out_ready <= (cyc_count % 4 == 0);
                endcase
            end
        end
    end

    task automatic wait_idle();
        while (pending_mults.size() != 0 || i_in_valid || expected_exits.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [cdc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cdc_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == cdc_pkg::REG_START_EXP)
            start_exp = val[cdc_pkg::START_EXP_W-1:0];
        else
            horizon = val[cdc_pkg::HORIZON_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_point(input int k, input int h);
        wait_idle();
        write_reg(cdc_pkg::REG_START_EXP, cdc_pkg::CFG_DATA_W'(k));
        write_reg(cdc_pkg::REG_HORIZON, cdc_pkg::CFG_DATA_W'(h));
        @(negedge i_clk);
    endtask

    task automatic queue_mult(input logic [cdc_pkg::MULT_W-1:0] m);
        pending_mults = {pending_mults, m};
    endtask

    task automatic add_random(input int n);
        repeat (n) queue_mult(pick_multiplier(start_exp));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: field extremes, zero and even multipliers
        queue_mult(64'd0);
        queue_mult(64'd1);
        queue_mult(64'd2);
        queue_mult(64'd3);
        queue_mult(64'd27);
        queue_mult(64'hFFFF_FFFF_FFFF_FFFF);
        queue_mult(64'h8000_0000_0000_0000);
        queue_mult(64'h8000_0000_0000_0001);
        queue_mult(64'h5555_5555_5555_5555);
        queue_mult(64'hAAAA_AAAA_AAAA_AAAA);
        queue_mult(64'h0000_0000_FFFF_FFFF);
        add_random(150);

        // k = 0 gives an immediate descent for most multipliers
        set_point(0, 50);
        queue_mult(64'd1);
        queue_mult(64'd2);
        queue_mult(64'd3);
        add_random(50);

        set_point(1, 1);
        queue_mult(64'd1);
        queue_mult(64'hFFFF_FFFF_FFFF_FFFF);
        add_random(40);

        // start never fits at the top exponent
        set_point(127, 200);
        queue_mult(64'd0);
        queue_mult(64'd1);
        queue_mult(64'hFFFF_FFFF_FFFF_FFFF);
        add_random(15);

        set_point(64, 65535);
        queue_mult(64'd1);
        queue_mult(64'd3);
        queue_mult(64'h0000_0000_03FF_FFFF);

        set_point(20, 300);
        add_random(120);

        set_point(40, 500);
        add_random(80);

        // horizon not beyond the start step
        set_point(3, 2);
        queue_mult(64'd7);
        add_random(40);

        set_point(5, 30);
        add_random(100);

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_exits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cdc_pkg.sv
hw/rtl/cdc_alu.sv
hw/rtl/collatz_descent_checker.sv
dv/tb_collatz_descent_checker.sv
